// ===== src/gag_pkg.sv =====
// Shared types and constants for the gather address generator.
// No dependencies; every other file refers to it by scoped names.
package gag_pkg;

  localparam int IDX_W      = 31;  // index value and shard offset
  localparam int CNT_W      = 16;  // outer/index counts and gather size
  localparam int INNER_W    = 7;   // inner size register and run length
  localparam int OUT_W      = 32;  // address ports
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int ROWQ_DEPTH = 4;   // row descriptor queue between front and back

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATHER_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET = 3'd4;

  // Per-row control carried with each descriptor
  typedef struct packed {
    logic               fill;      // whole row is zero fill
    logic               all_last;  // last index of last outer slice
    logic [INNER_W-1:0] run_len;   // effective inner size, 1..MAX_INNER
  } row_ctrl_t;

  localparam int ROW_CTRL_W = $bits(row_ctrl_t);

endpackage

// ===== src/gag_fifo.sv =====
// Small register queue for row descriptors (flat payload vector).
// Depends on gag_pkg for its depth.
module gag_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = gag_pkg::ROWQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/gag_front.sv =====
// Front end: accepts index words, classifies them against the shard,
// tracks outer/index positions and builds one row descriptor per word.
// Depends on gag_pkg.
module gag_front #(
  parameter int MAX_INNER = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [gag_pkg::IDX_W-1:0]     in_index_value,
  output logic                          in_full,
  input  logic [gag_pkg::CNT_W-1:0]     outer_count,
  input  logic [gag_pkg::CNT_W-1:0]     index_count,
  input  logic [gag_pkg::CNT_W-1:0]     gather_size,
  input  logic [gag_pkg::INNER_W-1:0]   inner_size,
  input  logic [gag_pkg::IDX_W-1:0]     index_offset,
  output logic                          row_push,
  output logic [ADDR_BITS-1:0]          row_src,
  output logic [ADDR_BITS-1:0]          row_dest,
  output gag_pkg::row_ctrl_t            row_ctrl,
  input  logic                          row_full
);

  localparam int CW = gag_pkg::CNT_W;
  localparam int IW = gag_pkg::IDX_W;
  localparam int NW = gag_pkg::INNER_W;
  localparam int PW = IW + NW;

  logic [CW-1:0]        outer_pos_r, outer_pos_nxt;
  logic [CW-1:0]        index_pos_r, index_pos_nxt;
  logic [ADDR_BITS-1:0] outer_base_r, outer_base_nxt;
  logic [ADDR_BITS-1:0] dest_run_r, dest_run_nxt;

  logic                 a_valid_r, a_valid_nxt;
  logic [IW-1:0]        a_shift_r;
  logic [ADDR_BITS-1:0] a_base_r;
  logic [ADDR_BITS-1:0] a_dest_r;
  gag_pkg::row_ctrl_t   a_ctrl_r;

  logic                 accept;
  logic [NW-1:0]        n_eff;
  logic                 below_off;
  logic [IW-1:0]        shifted;
  logic                 fill;
  logic                 last_index, last_outer;
  logic [CW:0]          ic_eff, oc_eff;
  logic [CW+NW-1:0]     slice_len;
  logic [PW-1:0]        row_offs;
  gag_pkg::row_ctrl_t   ctrl_nxt;

  // Stage A holds while the queue is full
  assign in_full = a_valid_r && row_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    if (inner_size == '0) begin
      n_eff = NW'(1);
    end else if (inner_size > NW'(MAX_INNER)) begin
      n_eff = NW'(MAX_INNER);
    end else begin
      n_eff = inner_size;
    end
  end

  assign below_off  = in_index_value < index_offset;
  assign shifted    = in_index_value - index_offset;
  assign fill       = below_off || (shifted >= IW'(gather_size));
  assign ic_eff     = (index_count == '0) ? (CW+1)'(1) : {1'b0, index_count};
  assign oc_eff     = (outer_count == '0) ? (CW+1)'(1) : {1'b0, outer_count};
  assign last_index = ({1'b0, index_pos_r} + 1'b1) >= ic_eff;
  assign last_outer = ({1'b0, outer_pos_r} + 1'b1) >= oc_eff;
  assign slice_len  = (CW+NW)'(gather_size) * (CW+NW)'(n_eff);

  always_comb begin
    ctrl_nxt.fill     = fill;
    ctrl_nxt.all_last = last_index && last_outer;
    ctrl_nxt.run_len  = n_eff;
  end

  // Advance positions and running bases on each accepted word
  always_comb begin
    outer_pos_nxt  = outer_pos_r;
    index_pos_nxt  = index_pos_r;
    outer_base_nxt = outer_base_r;
    dest_run_nxt   = dest_run_r;
    if (accept) begin
      if (last_index) begin
        index_pos_nxt = '0;
        if (last_outer) begin
          outer_pos_nxt  = '0;
          outer_base_nxt = '0;
          dest_run_nxt   = '0;
        end else begin
          outer_pos_nxt  = outer_pos_r + 1'b1;
          outer_base_nxt = outer_base_r + ADDR_BITS'(slice_len);
          dest_run_nxt   = dest_run_r + ADDR_BITS'(n_eff);
        end
      end else begin
        index_pos_nxt = index_pos_r + 1'b1;
        dest_run_nxt  = dest_run_r + ADDR_BITS'(n_eff);
      end
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (row_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_pos_r  <= '0;
      index_pos_r  <= '0;
      outer_base_r <= '0;
      dest_run_r   <= '0;
      a_valid_r    <= 1'b0;
    end else begin
      outer_pos_r  <= outer_pos_nxt;
      index_pos_r  <= index_pos_nxt;
      outer_base_r <= outer_base_nxt;
      dest_run_r   <= dest_run_nxt;
      a_valid_r    <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_shift_r <= fill ? '0 : shifted;
      a_base_r  <= outer_base_r;
      a_dest_r  <= dest_run_r;
      a_ctrl_r  <= ctrl_nxt;
    end
  end

  // Stage B: row source start = slice base + shifted index * run length
  assign row_offs = PW'(a_shift_r) * PW'(a_ctrl_r.run_len);
  assign row_push = a_valid_r && !row_full;
  assign row_src  = a_base_r + ADDR_BITS'(row_offs);
  assign row_dest = a_dest_r;
  assign row_ctrl = a_ctrl_r;

endmodule

// ===== src/gag_back.sv =====
// Back end: expands each row descriptor into one address word per element
// and holds the oldest word in the output register.
// Depends on gag_pkg.
module gag_back #(
  parameter int ADDR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          row_empty,
  input  logic [ADDR_BITS-1:0]          row_src,
  input  logic [ADDR_BITS-1:0]          row_dest,
  input  gag_pkg::row_ctrl_t            row_ctrl,
  output logic                          row_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [gag_pkg::OUT_W-1:0]     out_source_address,
  output logic [gag_pkg::OUT_W-1:0]     out_dest_address,
  output logic                          out_zero_fill,
  output logic                          out_run_last,
  output logic                          out_all_done
);

  localparam int NW = gag_pkg::INNER_W;
  localparam int OW = gag_pkg::OUT_W;

  logic                 run_active_r, run_active_nxt;
  logic [ADDR_BITS-1:0] src_r, dest_r;
  logic [NW-1:0]        elem_r;
  gag_pkg::row_ctrl_t   ctrl_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [OW-1:0]        out_src_r, out_dest_r;
  logic                 out_fill_r, out_last_r, out_done_r;

  logic                 emit;
  logic                 elem_last;

  assign emit      = run_active_r && (!out_valid_r || out_pop);
  assign elem_last = (elem_r + 1'b1) == ctrl_r.run_len;
  assign row_pop   = (!run_active_r || (emit && elem_last)) && !row_empty;

  always_comb begin
    run_active_nxt = run_active_r;
    if (row_pop) begin
      run_active_nxt = 1'b1;
    end else if (emit && elem_last) begin
      run_active_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      run_active_r <= run_active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Load a new row, or step through the current one
  always_ff @(posedge clk) begin
    if (row_pop) begin
      src_r  <= row_src;
      dest_r <= row_dest;
      elem_r <= '0;
      ctrl_r <= row_ctrl;
    end else if (emit) begin
      src_r  <= src_r + 1'b1;
      dest_r <= dest_r + 1'b1;
      elem_r <= elem_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_src_r  <= ctrl_r.fill ? '0 : OW'(src_r);
      out_dest_r <= OW'(dest_r);
      out_fill_r <= ctrl_r.fill;
      out_last_r <= elem_last;
      out_done_r <= elem_last && ctrl_r.all_last;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_source_address = out_src_r;
  assign out_dest_address   = out_dest_r;
  assign out_zero_fill      = out_fill_r;
  assign out_run_last       = out_last_r;
  assign out_all_done       = out_done_r;

endmodule

// ===== src/gather_address_generator.sv =====
// Top level of the gather address generator: configuration registers,
// front end, row descriptor queue and back end. Depends on gag_pkg,
// gag_front, gag_fifo and gag_back.
//
//  - Input: push index words in order, the whole list once per outer slice;
//    a word is taken at an edge with in_push high and in_full low.
//  - Results: while out_empty is low the oldest address word sits on the
//    out_ ports and is taken at an edge with out_pop high. Each index word
//    yields inner_size words (0 counts as 1, above MAX_INNER saturates);
//    run_last ends each row, all_done marks the final word of the gather.
//  - Configuration: write cfg_data to register cfg_index with cfg_we, only
//    while the block is idle; positions and bases are kept.
//  - Timing: a row passes stage A, the row queue and the back end's row registers
//    before its first word reaches the output register; the back end then emits one
//    word per cycle while out_pop keeps taking them, runs of one at one a cycle.
//  - Stalls: with out_pop low the output word holds; the back end and the
//    four-entry row queue fill up, then in_full rises. Nothing is dropped.
//  - Reset (rst_n low, synchronous): clear positions and bases, drop queued
//    rows, set counts and sizes to one and the offset to zero.
module gather_address_generator #(
  parameter int MAX_INNER = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [gag_pkg::IDX_W-1:0]         in_index_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [gag_pkg::OUT_W-1:0]         out_source_address,
  output logic [gag_pkg::OUT_W-1:0]         out_dest_address,
  output logic                              out_zero_fill,
  output logic                              out_run_last,
  output logic                              out_all_done,
  input  logic                              cfg_we,
  input  logic [gag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gag_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW  = gag_pkg::CNT_W;
  localparam int NW  = gag_pkg::INNER_W;
  localparam int IW  = gag_pkg::IDX_W;
  localparam int QW  = 2 * ADDR_BITS + gag_pkg::ROW_CTRL_W;

  logic [CW-1:0] outer_count_r, outer_count_nxt;
  logic [CW-1:0] index_count_r, index_count_nxt;
  logic [CW-1:0] gather_size_r, gather_size_nxt;
  logic [NW-1:0] inner_size_r, inner_size_nxt;
  logic [IW-1:0] index_offset_r, index_offset_nxt;

  // Register writes; unknown indexes are ignored
  always_comb begin
    outer_count_nxt  = outer_count_r;
    index_count_nxt  = index_count_r;
    gather_size_nxt  = gather_size_r;
    inner_size_nxt   = inner_size_r;
    index_offset_nxt = index_offset_r;
    if (cfg_we) begin
      case (cfg_index)
        gag_pkg::REG_OUTER_COUNT:  outer_count_nxt  = cfg_data[CW-1:0];
        gag_pkg::REG_INDEX_COUNT:  index_count_nxt  = cfg_data[CW-1:0];
        gag_pkg::REG_GATHER_SIZE:  gather_size_nxt  = cfg_data[CW-1:0];
        gag_pkg::REG_INNER_SIZE:   inner_size_nxt   = cfg_data[NW-1:0];
        gag_pkg::REG_INDEX_OFFSET: index_offset_nxt = cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_count_r  <= CW'(1);
      index_count_r  <= CW'(1);
      gather_size_r  <= CW'(1);
      inner_size_r   <= NW'(1);
      index_offset_r <= '0;
    end else begin
      outer_count_r  <= outer_count_nxt;
      index_count_r  <= index_count_nxt;
      gather_size_r  <= gather_size_nxt;
      inner_size_r   <= inner_size_nxt;
      index_offset_r <= index_offset_nxt;
    end
  end

  // Front to queue
  logic                 f_push, f_full;
  logic [ADDR_BITS-1:0] f_src, f_dest;
  gag_pkg::row_ctrl_t   f_ctrl;

  // Queue to back
  logic                 b_pop, b_empty;
  logic [QW-1:0]        q_rdata;
  logic [ADDR_BITS-1:0] b_src, b_dest;
  gag_pkg::row_ctrl_t   b_ctrl;

  gag_front #(
    .MAX_INNER (MAX_INNER),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_index_value (in_index_value),
    .in_full        (in_full),
    .outer_count    (outer_count_r),
    .index_count    (index_count_r),
    .gather_size    (gather_size_r),
    .inner_size     (inner_size_r),
    .index_offset   (index_offset_r),
    .row_push       (f_push),
    .row_src        (f_src),
    .row_dest       (f_dest),
    .row_ctrl       (f_ctrl),
    .row_full       (f_full)
  );

  gag_fifo #(
    .W (QW)
  ) u_rowq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_src, f_dest, f_ctrl}),
    .full  (f_full),
    .pop   (b_pop),
    .rdata (q_rdata),
    .empty (b_empty)
  );

  assign {b_src, b_dest, b_ctrl} = q_rdata;

  gag_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .row_empty          (b_empty),
    .row_src            (b_src),
    .row_dest           (b_dest),
    .row_ctrl           (b_ctrl),
    .row_pop            (b_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_zero_fill      (out_zero_fill),
    .out_run_last       (out_run_last),
    .out_all_done       (out_all_done)
  );

endmodule

// ===== verif/gag_tb_pkg.sv =====
// Address prediction and result checking for the gather address generator bench.
// Holds its own copy of the registers, positions and bases; depends on gag_pkg.
package gag_tb_pkg;

  localparam int RUN_MAX = 64;  // widest row the block is built for

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic        fill;
    logic        row_end;
    logic        gather_end;
  } addr_word_t;

  class gather_tracker;
    bit [15:0]  outer_cnt;
    bit [15:0]  index_cnt;
    bit [15:0]  gather_len;
    bit [6:0]   inner_len;
    bit [30:0]  shard_offset;
    bit [15:0]  outer_pos;
    bit [15:0]  index_pos;
    bit [31:0]  src_base;
    bit [31:0]  dest_base;
    addr_word_t expected_words[$];
    int         mismatch_count;

    function new();
      outer_cnt      = 16'd1;
      index_cnt      = 16'd1;
      gather_len     = 16'd1;
      inner_len      = 7'd1;
      shard_offset   = '0;
      outer_pos      = '0;
      index_pos      = '0;
      src_base       = '0;
      dest_base      = '0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [gag_pkg::CFG_IDX_W-1:0] idx, logic [30:0] data);
      case (idx)
        gag_pkg::REG_OUTER_COUNT:  outer_cnt    = data[15:0];
        gag_pkg::REG_INDEX_COUNT:  index_cnt    = data[15:0];
        gag_pkg::REG_GATHER_SIZE:  gather_len   = data[15:0];
        gag_pkg::REG_INNER_SIZE:   inner_len    = data[6:0];
        gag_pkg::REG_INDEX_OFFSET: shard_offset = data;
        default: ;
      endcase
    endfunction

    function int unsigned run_length();
      if (inner_len == 0) return 1;
      if (inner_len > RUN_MAX) return RUN_MAX;
      return inner_len;
    endfunction

    // Expand one index word into its row of address words.
    function void note_index(logic [30:0] value);
      int unsigned run;
      int unsigned oc;
      int unsigned ic;
      int unsigned k;
      bit [31:0]   shifted;
      bit          fill;
      bit          last_idx;
      bit          last_outer;
      addr_word_t  w;
      run     = run_length();
      oc      = (outer_cnt == 0) ? 1 : outer_cnt;
      ic      = (index_cnt == 0) ? 1 : index_cnt;
      fill    = 1'b1;
      shifted = '0;
      if (value >= shard_offset) begin
        shifted = value - shard_offset;
        if (shifted < gather_len) fill = 1'b0;
      end
      last_idx   = (index_pos + 32'd1) >= ic;
      last_outer = (outer_pos + 32'd1) >= oc;
      for (k = 0; k < run; k++) begin
        w.src        = fill ? 32'd0 : src_base + shifted * run + k;
        w.dst        = dest_base + k;
        w.fill       = fill;
        w.row_end    = (k + 1 == run);
        w.gather_end = w.row_end && last_idx && last_outer;
        expected_words.push_back(w);
      end
      if (last_idx) begin
        index_pos = '0;
        if (last_outer) begin
          outer_pos = '0;
          src_base  = '0;
          dest_base = '0;
        end else begin
          outer_pos = outer_pos + 16'd1;
          src_base  = src_base + gather_len * run;
          dest_base = dest_base + run;
        end
      end else begin
        index_pos = index_pos + 16'd1;
        dest_base = dest_base + run;
      end
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= 30) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_word(logic [31:0] src, logic [31:0] dst, logic fill, logic row_end,
                    logic gather_end);
      addr_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word src=%h dst=%h", src, dst));
      end else begin
        w = expected_words.pop_front();
        if (src !== w.src)
          report($sformatf("source_address %h, expected %h", src, w.src));
        if (dst !== w.dst)
          report($sformatf("dest_address %h, expected %h", dst, w.dst));
        if (fill !== w.fill)
          report($sformatf("zero_fill %b, expected %b (dst %h)", fill, w.fill, w.dst));
        if (row_end !== w.row_end)
          report($sformatf("run_last %b, expected %b (dst %h)", row_end, w.row_end, w.dst));
        if (gather_end !== w.gather_end)
          report($sformatf("all_done %b, expected %b (dst %h)", gather_end, w.gather_end,
                           w.dst));
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
// Top-level bench for gather_address_generator: drives index words and register
// writes, checks every address word against gag_tb_pkg's tracker. Needs gag_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 10_000_000;  // cycles before the run is declared hung
  localparam int SETTLE     = 8;           // quiet cycles before a register write
  localparam int TAIL       = 80;          // watch for stray words at the end
  localparam int HOLD_OFF   = 300;         // one long receiver stall
  localparam int WRAP_ITEMS = 16;          // back-to-back widest rows, largest shard

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_push;
  logic                             in_full;
  logic [gag_pkg::IDX_W-1:0]        in_index_value;
  logic                             out_empty;
  logic                             out_pop;
  logic [gag_pkg::OUT_W-1:0]        out_source_address;
  logic [gag_pkg::OUT_W-1:0]        out_dest_address;
  logic                             out_zero_fill;
  logic                             out_run_last;
  logic                             out_all_done;
  logic                             cfg_we;
  logic [gag_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [gag_pkg::CFG_DATA_W-1:0]   cfg_data;

  gag_tb_pkg::gather_tracker tracker = new();

  bit          calm;     // no idling on either side while set
  bit          squeeze;  // ask the receiver for its one long stall
  int unsigned cycle_count;

  gather_address_generator #(
    .MAX_INNER(gag_tb_pkg::RUN_MAX),
    .ADDR_BITS(32)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_index_value    (in_index_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_source_address(out_source_address),
    .out_dest_address  (out_dest_address),
    .out_zero_fill     (out_zero_fill),
    .out_run_last      (out_run_last),
    .out_all_done      (out_all_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick an index word: mostly inside the shard, some on its borders, some anywhere
  // in the 31-bit range so that every bit of the field toggles.
  function automatic logic [30:0] pick_index();
    int unsigned r;
    logic [31:0] lo;
    logic [31:0] hi;
    r  = $urandom_range(0, 99);
    lo = {1'b0, tracker.shard_offset};
    hi = lo + tracker.gather_len;  // one past the last index in range
    if (hi > 32'h7FFF_FFFF) hi = 32'h8000_0000;
    if (r < 70 && tracker.gather_len != 0) return 31'($urandom_range(hi - 1, lo));
    if (r < 80) return (lo == 0) ? 31'd0 : 31'(lo - 1);
    if (r < 90) return hi[31] ? 31'h7FFF_FFFF : hi[30:0];
    return 31'($urandom);
  endfunction

  // Write one register; the block takes it at the rising edge in between.
  task automatic write_reg(input logic [gag_pkg::CFG_IDX_W-1:0] idx, input logic [30:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one index word and hold it until the block takes it, then idle a while.
  task automatic send(input logic [30:0] value);
    int unsigned gap;
    @(negedge clk);
    in_push        = 1'b1;
    in_index_value = value;
    do @(posedge clk); while (in_full !== 1'b0);
    tracker.note_index(value);
    gap = gap_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_push        = 1'b0;
      in_index_value = 31'($urandom);
    end
  endtask

  // Drop push, wait for every expected word, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    in_push = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Fresh register set: small counts so whole gathers complete, occasional
  // zero and saturating values, offsets from zero to the top of the range.
  task automatic random_config();
    int unsigned r;
    r = $urandom_range(0, 9);
    write_reg(gag_pkg::REG_OUTER_COUNT, (r == 0) ? 31'd0 : 31'($urandom_range(1, 4)));
    r = $urandom_range(0, 9);
    write_reg(gag_pkg::REG_INDEX_COUNT, (r == 0) ? 31'd0 : 31'($urandom_range(1, 6)));
    r = $urandom_range(0, 9);
    write_reg(gag_pkg::REG_GATHER_SIZE, (r == 0) ? 31'd0 :
                                        (r == 1) ? 31'd65535 : 31'($urandom_range(1, 300)));
    r = $urandom_range(0, 19);
    write_reg(gag_pkg::REG_INNER_SIZE, (r < 2) ? 31'd0 :
                                       (r < 4) ? 31'd64 :
                                       (r == 4) ? 31'($urandom_range(65, 127)) :
                                       31'($urandom_range(1, 8)));
    r = $urandom_range(0, 9);
    write_reg(gag_pkg::REG_INDEX_OFFSET, (r < 2) ? 31'd0 :
                                         (r == 2) ? 31'($urandom_range(1, 1000)) :
                                         (r == 3) ? 31'h7FFF_FFFF : 31'($urandom));
  endtask

  task automatic random_phase(input int unsigned n_items, input bit with_hold);
    int unsigned i;
    random_config();
    for (i = 0; i < n_items; i++) begin
      if (with_hold && i == 10) squeeze = 1'b1;
      send(pick_index());
    end
    settle();
  endtask

  // Result side: take the word on the ports at a rising edge with pop high,
  // then choose pop for the next cycle at the falling edge.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    out_pop    = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0)
        tracker.check_word(out_source_address, out_dest_address, out_zero_fill,
                           out_run_last, out_all_done);
      @(negedge clk);
      // Hold off once for a long stretch so the row queue fills and in_full rises.
      if (squeeze && !held) begin
        held      = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_pop = 1'b0;
      end else begin
        out_pop    = 1'b1;
        stall_left = gap_cycles();
      end
    end
  end

  // Watchdog: stop a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned ph;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_index_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = gag_pkg::REG_OUTER_COUNT;
    cfg_data       = '0;
    calm           = 1'b0;
    squeeze        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one-element gather, every word is a whole gather.
    send(31'd0);
    send(31'd1);
    send(31'h7FFF_FFFF);
    settle();

    // Two outer slices of three indexes: first and last in shard, one past the
    // end, one below the offset, the extremes of the field.
    write_reg(gag_pkg::REG_OUTER_COUNT, 31'd2);
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd3);
    write_reg(gag_pkg::REG_GATHER_SIZE, 31'd10);
    write_reg(gag_pkg::REG_INNER_SIZE, 31'd5);
    write_reg(gag_pkg::REG_INDEX_OFFSET, 31'd100);
    send(31'd100);
    send(31'd109);
    send(31'd110);
    send(31'd99);
    send(31'h7FFF_FFFF);
    send(31'd0);
    settle();

    // Zero counts act as one, zero inner size as one, empty shard fills all.
    write_reg(gag_pkg::REG_OUTER_COUNT, 31'd0);
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd0);
    write_reg(gag_pkg::REG_GATHER_SIZE, 31'd0);
    write_reg(gag_pkg::REG_INNER_SIZE, 31'd0);
    write_reg(gag_pkg::REG_INDEX_OFFSET, 31'd0);
    send(31'd0);
    send(31'd3);
    settle();

    // Largest counts and shard, inner size saturating at the row limit.
    write_reg(gag_pkg::REG_OUTER_COUNT, 31'd65535);
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd65535);
    write_reg(gag_pkg::REG_GATHER_SIZE, 31'd65535);
    write_reg(gag_pkg::REG_INNER_SIZE, 31'd127);
    send(31'h7FFF_FFFF);
    send(31'd65534);
    send(31'd0);
    settle();

    // Change the counts mid gather: positions carry over, and a position already
    // past the new index count wraps on the next word. Then the top offset.
    write_reg(gag_pkg::REG_OUTER_COUNT, 31'd3);
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd8);
    write_reg(gag_pkg::REG_GATHER_SIZE, 31'd1000);
    write_reg(gag_pkg::REG_INNER_SIZE, 31'd3);
    write_reg(gag_pkg::REG_INDEX_OFFSET, 31'd50);
    send(31'd50);
    send(31'd1049);
    send(31'd1050);
    send(31'd49);
    settle();
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd2);
    write_reg(gag_pkg::REG_INDEX_OFFSET, 31'h7FFF_FFFF);
    send(31'h7FFF_FFFF);
    send(31'h7FFF_FFFE);
    send(31'h7FFF_FFFF);
    settle();

    // First random phase carries the long receiver stall.
    random_phase(45, 1'b1);

    // Widest rows at the largest shard, one index per slice, with no idling.
    calm = 1'b1;
    write_reg(gag_pkg::REG_OUTER_COUNT, 31'd65535);
    write_reg(gag_pkg::REG_INDEX_COUNT, 31'd1);
    write_reg(gag_pkg::REG_GATHER_SIZE, 31'd65535);
    write_reg(gag_pkg::REG_INNER_SIZE, 31'd64);
    write_reg(gag_pkg::REG_INDEX_OFFSET, 31'd0);
    for (i = 0; i < WRAP_ITEMS; i++)
      send(($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 65534)));
    calm = 1'b0;
    settle();

    // Remaining random phases; one of them runs with no idling at all.
    for (ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      random_phase(45, 1'b0);
    end
    calm = 1'b0;

    // Everything expected has arrived; watch a while longer for stray words.
    settle();
    repeat (TAIL) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
